// ===== design/ewpl_pkg.sv =====
// ewpl_pkg: shared types and constants for the event wait priority list.
// Used by ewpl_store, ewpl_seq, the top level and the checker.
package ewpl_pkg;

  // Parameter defaults
  localparam int MAX_THREADS_DEF = 16;
  localparam int PRIO_BITS_DEF   = 8;

  // Fixed port field widths
  localparam int THREAD_W = 4;
  localparam int PRIO_W   = 8;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_DUP    = 2'd1,
    STS_ABSENT = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LINK_SELF,
    ST_LINK_NBR,
    ST_REM_RD,
    ST_REM_UPD,
    ST_DONE
  } seq_state_t;

  // Write enables of the link store
  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic prio_we;
  } store_we_t;

  // One result word
  typedef struct packed {
    logic [THREAD_W-1:0] head_thread;
    logic                list_empty;
    logic [COUNT_W-1:0]  thread_count;
    status_t             status;
  } result_t;

endpackage

// ===== design/ewpl_store.sv =====
// ewpl_store: link store holding next link, previous link and priority per slot.
// One shared read address with registered read data, one write port per array.
// Depends on ewpl_pkg.
module ewpl_store #(
  parameter int MAX_THREADS = ewpl_pkg::MAX_THREADS_DEF,
  parameter int PRIO_BITS   = ewpl_pkg::PRIO_BITS_DEF
) (
  input  logic                               clk,
  input  logic [$clog2(MAX_THREADS)-1:0]     rd_addr,
  output logic [$clog2(MAX_THREADS+1)-1:0]   rd_next,
  output logic [$clog2(MAX_THREADS+1)-1:0]   rd_prev,
  output logic [PRIO_BITS-1:0]               rd_prio,
  input  ewpl_pkg::store_we_t                wr_we,
  input  logic [$clog2(MAX_THREADS)-1:0]     next_addr,
  input  logic [$clog2(MAX_THREADS+1)-1:0]   next_data,
  input  logic [$clog2(MAX_THREADS)-1:0]     prev_addr,
  input  logic [$clog2(MAX_THREADS+1)-1:0]   prev_data,
  input  logic [$clog2(MAX_THREADS)-1:0]     prio_addr,
  input  logic [PRIO_BITS-1:0]               prio_data
);

  localparam int LW = $clog2(MAX_THREADS + 1);

  logic [LW-1:0]        next_mem [MAX_THREADS];
  logic [LW-1:0]        prev_mem [MAX_THREADS];
  logic [PRIO_BITS-1:0] prio_mem [MAX_THREADS];

  logic [LW-1:0]        rd_next_r;
  logic [LW-1:0]        rd_prev_r;
  logic [PRIO_BITS-1:0] rd_prio_r;

  // Writes
  always_ff @(posedge clk) begin
    if (wr_we.next_we) begin
      next_mem[next_addr] <= next_data;
    end
    if (wr_we.prev_we) begin
      prev_mem[prev_addr] <= prev_data;
    end
    if (wr_we.prio_we) begin
      prio_mem[prio_addr] <= prio_data;
    end
  end

  // Registered read, all arrays at the same slot
  always_ff @(posedge clk) begin
    rd_next_r <= next_mem[rd_addr];
    rd_prev_r <= prev_mem[rd_addr];
    rd_prio_r <= prio_mem[rd_addr];
  end

  assign rd_next = rd_next_r;
  assign rd_prev = rd_prev_r;
  assign rd_prio = rd_prio_r;

endmodule

// ===== design/ewpl_seq.sv =====
// ewpl_seq: sequencer for insert walk, link update and unlink.
// Owns head, count and the listed bits; drives ewpl_store. Depends on ewpl_pkg.
module ewpl_seq #(
  parameter int MAX_THREADS = ewpl_pkg::MAX_THREADS_DEF,
  parameter int PRIO_BITS   = ewpl_pkg::PRIO_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input word
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_operation,
  input  logic [ewpl_pkg::THREAD_W-1:0]      in_thread_id,
  input  logic [ewpl_pkg::PRIO_W-1:0]        in_priority_req,
  // link store
  output logic [$clog2(MAX_THREADS)-1:0]     rd_addr,
  input  logic [$clog2(MAX_THREADS+1)-1:0]   rd_next,
  input  logic [$clog2(MAX_THREADS+1)-1:0]   rd_prev,
  input  logic [PRIO_BITS-1:0]               rd_prio,
  output ewpl_pkg::store_we_t                wr_we,
  output logic [$clog2(MAX_THREADS)-1:0]     next_addr,
  output logic [$clog2(MAX_THREADS+1)-1:0]   next_data,
  output logic [$clog2(MAX_THREADS)-1:0]     prev_addr,
  output logic [$clog2(MAX_THREADS+1)-1:0]   prev_data,
  output logic [$clog2(MAX_THREADS)-1:0]     prio_addr,
  output logic [PRIO_BITS-1:0]               prio_data,
  // result
  output logic                               res_valid,
  output ewpl_pkg::result_t                  res,
  input  logic                               res_take
);

  localparam int SW = $clog2(MAX_THREADS);
  localparam int LW = $clog2(MAX_THREADS + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_THREADS);

  ewpl_pkg::seq_state_t state_r, state_nxt;
  logic [SW-1:0]          t_r, t_nxt;
  logic [PRIO_BITS-1:0]   prio_r, prio_nxt;
  logic [LW-1:0]          cur_r, cur_nxt;
  logic [LW-1:0]          last_r, last_nxt;
  logic [LW-1:0]          steps_r, steps_nxt;
  ewpl_pkg::status_t      status_r, status_nxt;
  logic [LW-1:0]          head_r, head_nxt;
  logic [LW-1:0]          count_r, count_nxt;
  logic [MAX_THREADS-1:0] in_list_r, in_list_nxt;

  logic          accept;
  logic [SW-1:0] in_slot;
  logic          in_range;
  logic          in_listed;
  logic          ins_reject;
  logic          head_null;
  logic          cur_null;
  logic          last_null;
  logic          rd_next_null;
  logic          rd_prev_null;
  logic          go_on;
  logic [LW-1:0] t_link;
  logic          res_empty;

  // Decode of the incoming word and link tests
  assign accept       = in_valid && (state_r == ewpl_pkg::ST_IDLE);
  assign in_slot      = SW'(in_thread_id);
  assign in_range     = (32'(in_thread_id) < 32'(MAX_THREADS));
  assign in_listed    = in_range && in_list_r[in_slot];
  assign ins_reject   = !in_range || in_listed;
  assign head_null    = (head_r >= NULL_LINK);
  assign cur_null     = (cur_r >= NULL_LINK);
  assign last_null    = (last_r >= NULL_LINK);
  assign rd_next_null = (rd_next >= NULL_LINK);
  assign rd_prev_null = (rd_prev >= NULL_LINK);
  assign t_link       = LW'(t_r);

  // Shared compare: keep walking past entries of equal or lower priority value
  assign go_on = (rd_prio <= prio_r) && (steps_r < NULL_LINK);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ewpl_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_operation == ewpl_pkg::OP_INSERT) begin
            if (ins_reject) begin
              state_nxt = ewpl_pkg::ST_DONE;
            end else if (head_null) begin
              state_nxt = ewpl_pkg::ST_LINK_SELF;
            end else begin
              state_nxt = ewpl_pkg::ST_WALK;
            end
          end else begin
            state_nxt = in_listed ? ewpl_pkg::ST_REM_RD : ewpl_pkg::ST_DONE;
          end
        end
      end
      ewpl_pkg::ST_WALK: begin
        if (!(go_on && !rd_next_null)) begin
          state_nxt = ewpl_pkg::ST_LINK_SELF;
        end
      end
      ewpl_pkg::ST_LINK_SELF: state_nxt = ewpl_pkg::ST_LINK_NBR;
      ewpl_pkg::ST_LINK_NBR:  state_nxt = ewpl_pkg::ST_DONE;
      ewpl_pkg::ST_REM_RD:    state_nxt = ewpl_pkg::ST_REM_UPD;
      ewpl_pkg::ST_REM_UPD:   state_nxt = ewpl_pkg::ST_DONE;
      ewpl_pkg::ST_DONE: begin
        if (res_take) begin
          state_nxt = ewpl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ewpl_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates and store control
  always_comb begin
    t_nxt       = t_r;
    prio_nxt    = prio_r;
    cur_nxt     = cur_r;
    last_nxt    = last_r;
    steps_nxt   = steps_r;
    status_nxt  = status_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    in_list_nxt = in_list_r;
    rd_addr     = head_r[SW-1:0];
    wr_we       = '0;
    next_addr   = t_r;
    next_data   = cur_r;
    prev_addr   = t_r;
    prev_data   = last_r;
    prio_addr   = t_r;
    prio_data   = prio_r;
    case (state_r)
      ewpl_pkg::ST_IDLE: begin
        // read at the head so the first walk step finds its data
        rd_addr = head_r[SW-1:0];
        if (accept) begin
          t_nxt     = in_slot;
          prio_nxt  = PRIO_BITS'(in_priority_req);
          cur_nxt   = head_r;
          last_nxt  = NULL_LINK;
          steps_nxt = '0;
          if (in_operation == ewpl_pkg::OP_INSERT) begin
            status_nxt = ins_reject ? ewpl_pkg::STS_DUP : ewpl_pkg::STS_OK;
          end else begin
            status_nxt = in_listed ? ewpl_pkg::STS_OK : ewpl_pkg::STS_ABSENT;
          end
        end
      end
      ewpl_pkg::ST_WALK: begin
        // one link per cycle: next address comes straight from read data
        rd_addr = rd_next[SW-1:0];
        if (go_on) begin
          last_nxt  = cur_r;
          cur_nxt   = rd_next_null ? NULL_LINK : rd_next;
          steps_nxt = steps_r + LW'(1);
        end
      end
      ewpl_pkg::ST_LINK_SELF: begin
        wr_we.next_we = 1'b1;
        wr_we.prev_we = 1'b1;
        wr_we.prio_we = 1'b1;
      end
      ewpl_pkg::ST_LINK_NBR: begin
        wr_we.next_we = !last_null;
        next_addr     = last_r[SW-1:0];
        next_data     = t_link;
        wr_we.prev_we = !cur_null;
        prev_addr     = cur_r[SW-1:0];
        prev_data     = t_link;
        if (last_null) begin
          head_nxt = t_link;
        end
        in_list_nxt[t_r] = 1'b1;
        count_nxt        = count_r + LW'(1);
      end
      ewpl_pkg::ST_REM_RD: begin
        rd_addr = t_r;
      end
      ewpl_pkg::ST_REM_UPD: begin
        // bridge the neighbors over the removed slot
        wr_we.next_we = !rd_prev_null;
        next_addr     = rd_prev[SW-1:0];
        next_data     = rd_next;
        wr_we.prev_we = !rd_next_null;
        prev_addr     = rd_next[SW-1:0];
        prev_data     = rd_prev;
        if (head_r == t_link) begin
          head_nxt = rd_next_null ? NULL_LINK : rd_next;
        end
        in_list_nxt[t_r] = 1'b0;
        if (count_r != '0) begin
          count_nxt = count_r - LW'(1);
        end
      end
      ewpl_pkg::ST_DONE: begin
        rd_addr = head_r[SW-1:0];
      end
      default: begin
        rd_addr = head_r[SW-1:0];
      end
    endcase
  end

  // Result word
  assign in_stall         = (state_r != ewpl_pkg::ST_IDLE);
  assign res_valid        = (state_r == ewpl_pkg::ST_DONE);
  assign res_empty        = head_null;
  assign res.head_thread  = res_empty ? '0 : ewpl_pkg::THREAD_W'(head_r);
  assign res.list_empty   = res_empty;
  assign res.thread_count = ewpl_pkg::COUNT_W'(count_r);
  assign res.status       = status_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ewpl_pkg::ST_IDLE;
      head_r    <= NULL_LINK;
      count_r   <= '0;
      in_list_r <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      in_list_r <= in_list_nxt;
    end
  end

  // Working registers of the current word
  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    prio_r   <= prio_nxt;
    cur_r    <= cur_nxt;
    last_r   <= last_nxt;
    steps_r  <= steps_nxt;
    status_r <= status_nxt;
  end

endmodule

// ===== design/event_wait_priority_list_top.sv =====
// Event wait priority list, top level: sequencer, link store and output register.
// Depends on ewpl_pkg, ewpl_store and ewpl_seq.
//
// Keeps the threads waiting on one event as a doubly linked list over
// MAX_THREADS slots, sorted by priority (lower value first, equal priority
// after those already listed). Each input word either inserts a thread or
// removes it and returns one word: head thread, empty flag, count and status.
// An insert of a listed thread or a removal of an absent one leaves the list
// alone and reports it in status. One word is worked on at a time: an insert
// walks from the head past the listed threads of equal or lower priority
// value (at most MAX_THREADS - 1), and a remove reads the slot of the thread
// and bridges its neighbours over it; a rejected word goes straight to its result.
// The walk visits one link per cycle through the single registered read port
// of the link store; an insert writes its own links in ST_LINK_SELF, then its neighbours' links in ST_LINK_NBR.
// The next word is accepted the cycle after the result is loaded, even while
// that result still waits on out_stall. No clearing pass is needed at reset.
module event_wait_priority_list_top #(
  parameter int MAX_THREADS = ewpl_pkg::MAX_THREADS_DEF,
  parameter int PRIO_BITS   = ewpl_pkg::PRIO_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [ewpl_pkg::THREAD_W-1:0]  in_thread_id,
  input  logic [ewpl_pkg::PRIO_W-1:0]    in_priority_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ewpl_pkg::THREAD_W-1:0]  out_head_thread,
  output logic                           out_list_empty,
  output logic [ewpl_pkg::COUNT_W-1:0]   out_thread_count,
  output logic [ewpl_pkg::STATUS_W-1:0]  out_status
);

  localparam int SW = $clog2(MAX_THREADS);
  localparam int LW = $clog2(MAX_THREADS + 1);

  logic [SW-1:0]        rd_addr;
  logic [LW-1:0]        rd_next;
  logic [LW-1:0]        rd_prev;
  logic [PRIO_BITS-1:0] rd_prio;
  ewpl_pkg::store_we_t  wr_we;
  logic [SW-1:0]        next_addr;
  logic [LW-1:0]        next_data;
  logic [SW-1:0]        prev_addr;
  logic [LW-1:0]        prev_data;
  logic [SW-1:0]        prio_addr;
  logic [PRIO_BITS-1:0] prio_data;

  logic              res_valid;
  ewpl_pkg::result_t res;
  logic              res_take;

  logic              out_valid_r, out_valid_nxt;
  ewpl_pkg::result_t out_word_r, out_word_nxt;

  ewpl_seq #(
    .MAX_THREADS (MAX_THREADS),
    .PRIO_BITS   (PRIO_BITS)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_thread_id    (in_thread_id),
    .in_priority_req (in_priority_req),
    .rd_addr         (rd_addr),
    .rd_next         (rd_next),
    .rd_prev         (rd_prev),
    .rd_prio         (rd_prio),
    .wr_we           (wr_we),
    .next_addr       (next_addr),
    .next_data       (next_data),
    .prev_addr       (prev_addr),
    .prev_data       (prev_data),
    .prio_addr       (prio_addr),
    .prio_data       (prio_data),
    .res_valid       (res_valid),
    .res             (res),
    .res_take        (res_take)
  );

  ewpl_store #(
    .MAX_THREADS (MAX_THREADS),
    .PRIO_BITS   (PRIO_BITS)
  ) u_store (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .rd_next   (rd_next),
    .rd_prev   (rd_prev),
    .rd_prio   (rd_prio),
    .wr_we     (wr_we),
    .next_addr (next_addr),
    .next_data (next_data),
    .prev_addr (prev_addr),
    .prev_data (prev_data),
    .prio_addr (prio_addr),
    .prio_data (prio_data)
  );

  // Output register: load when empty or being drained
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (res_take) begin
      out_word_nxt  = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_head_thread  = out_word_r.head_thread;
  assign out_list_empty   = out_word_r.list_empty;
  assign out_thread_count = out_word_r.thread_count;
  assign out_status       = out_word_r.status;

endmodule

// ===== design/ewpl_checker.sv =====
// ewpl_checker: port-level assertions for event_wait_priority_list_top.
// Bound to the top level below. Depends on ewpl_pkg.
module ewpl_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ewpl_pkg::THREAD_W-1:0]  out_head_thread,
  input logic                           out_list_empty,
  input logic [ewpl_pkg::COUNT_W-1:0]   out_thread_count,
  input logic [ewpl_pkg::STATUS_W-1:0]  out_status
);

  // No result word right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_head_thread) &&
      $stable(out_list_empty) && $stable(out_thread_count) && $stable(out_status))
    else $error("stalled result changed");

  // One word in work at a time: busy right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  // Empty list reports head zero and count zero
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_list_empty |-> out_head_thread == '0 && out_thread_count == '0)
    else $error("empty list with nonzero head or count");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ewpl_pkg::STS_OK || out_status == ewpl_pkg::STS_DUP ||
      out_status == ewpl_pkg::STS_ABSENT)
    else $error("undefined status code");

endmodule

bind event_wait_priority_list_top ewpl_checker u_ewpl_checker (.*);
